// File: rtl/scan_disk_scheduler_macros.svh
// Assertion helpers shared by the scheduler files.
`ifndef SCAN_DISK_SCHEDULER_MACROS_SVH
`define SCAN_DISK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scan_disk_scheduler: assertion failed");

// Next-cycle implication, checked outside reset.
`define SDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scan_disk_scheduler: assertion failed");

`endif

// File: rtl/sds_pkg.sv
package sds_pkg;

   // Field widths.
   localparam int CYL_W   = 16;
   localparam int NCYL_W  = 17;
   localparam int TOTAL_W = 22;

   // Register port.
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Default store depth.
   localparam int MAX_REQUESTS_DEF = 16;

   // Register reset values.
   localparam logic [NCYL_W-1:0] NUM_CYL_RESET  = NCYL_W'(200);
   localparam logic [CYL_W-1:0]  LAST_CYL_RESET = CYL_W'(199);

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_NUM_CYLINDERS = 2'd0,
      REG_HEAD_POSITION = 2'd1,
      REG_PREV_POSITION = 2'd2
   } reg_index_type;

   // Scheduler states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SWEEP1,
      ST_END,
      ST_SWEEP2
   } state_type;

   // What one sorting cell hands to its right-hand neighbor.
   typedef struct packed {
      logic             valid;
      logic             le;
      logic [CYL_W-1:0] value;
   } cell_link_type;

endpackage

// File: rtl/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler.
// Request channel (req_*): one request cylinder per transaction, clamped to
// the last cylinder and inserted into a sorted row of cells, so a
// batch loads at one request per cycle. Requests beyond the row depth are
// dropped. The transaction with req_last_request set starts the schedule.
// While a schedule runs, req_ready is low.
// Schedule: the row is scanned from the low end for the head's split point s,
// one cell per cycle, then one leg is produced per cycle as long as the
// response register is free: the current sweep, the leg to the disk end, then
// the return sweep if any requests lie behind the head. The step that ends
// the first sweep produces no leg; the end leg follows it.
// Response channel (rsp_*): a registered output; a stalled receiver holds
// the leg in place and the schedule waits for it, losing nothing.
// Configuration: APB registers at byte addresses 0, 4 and 8 (cylinder count,
// head, previous head); the user must write them only while the block is idle,
// a rule the block does not enforce. Reset: store empty, registers 200, 0 and 0.
`include "scan_disk_scheduler_macros.svh"

module scan_disk_scheduler #(
   parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sds_pkg::CYL_W-1:0]         req_request_cylinder,
   input  logic                              req_last_request,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sds_pkg::CYL_W-1:0]         rsp_from_cylinder,
   output logic [sds_pkg::CYL_W-1:0]         rsp_to_cylinder,
   output logic [sds_pkg::CYL_W-1:0]         rsp_seek_distance,
   output logic [sds_pkg::TOTAL_W-1:0]       rsp_total_movement,
   output logic                              rsp_last_leg,
   // Configuration port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sds_pkg::ADDR_W-1:0]        paddr,
   input  logic [sds_pkg::DATA_W-1:0]        pwdata,
   output logic [sds_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W = $clog2(MAX_REQUESTS);
   localparam int CYL_W = sds_pkg::CYL_W;
   localparam int TOT_W = sds_pkg::TOTAL_W;
   localparam int NC_W  = sds_pkg::NCYL_W;

   // Configuration registers.
   logic [NC_W-1:0]     num_cyl_ff;
   logic [CYL_W-1:0]    last_cyl_ff;
   logic [CYL_W-1:0]    head_ff;
   logic [CYL_W-1:0]    prev_ff;
   logic                cfg_wr;
   logic [NC_W-1:0]     wr_ncyl;
   logic [CYL_W-1:0]    wr_last;
   sds_pkg::reg_index_type reg_idx;

   // Scheduler state.
   sds_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    split_ff, split_in;
   logic [CYL_W-1:0]    pos_ff, pos_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic                up_ff, up_in;

   // Response register.
   logic                rsp_valid_ff;
   logic [CYL_W-1:0]    rsp_from_ff, rsp_to_ff, rsp_dist_ff;
   logic [TOT_W-1:0]    rsp_total_ff;
   logic                rsp_last_ff;

   // Datapath.
   logic                accept;
   logic                ins_ok;
   logic [CYL_W-1:0]    req_clamped;
   logic [CYL_W-1:0]    head_clamped;
   logic [CYL_W-1:0]    rd_value;
   logic [CNT_W-1:0]    rd_ptr;
   logic                asc;
   logic                below;
   logic                scan_more;
   logic                out_free;
   logic                done1;
   logic                emit;
   logic                leg_final;
   logic [CYL_W-1:0]    leg_to;
   logic [CYL_W-1:0]    leg_dist;

   // Register write decode; the last cylinder is derived at write time.
   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign reg_idx = sds_pkg::reg_index_type'(paddr[3:2]);
   assign wr_ncyl = pwdata[NC_W-1:0];

   always_comb begin
      if (wr_ncyl < NC_W'(2)) begin
         wr_last = CYL_W'(1);
      end else if (wr_ncyl > NC_W'(65536)) begin
         wr_last = '1;
      end else begin
         wr_last = CYL_W'(wr_ncyl - NC_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cyl_ff  <= sds_pkg::NUM_CYL_RESET;
         last_cyl_ff <= sds_pkg::LAST_CYL_RESET;
         head_ff     <= '0;
         prev_ff     <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            sds_pkg::REG_NUM_CYLINDERS: begin
               num_cyl_ff  <= wr_ncyl;
               last_cyl_ff <= wr_last;
            end
            sds_pkg::REG_HEAD_POSITION: head_ff <= pwdata[CYL_W-1:0];
            sds_pkg::REG_PREV_POSITION: prev_ff <= pwdata[CYL_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (reg_idx)
         sds_pkg::REG_NUM_CYLINDERS: prdata = sds_pkg::DATA_W'(num_cyl_ff);
         sds_pkg::REG_HEAD_POSITION: prdata = sds_pkg::DATA_W'(head_ff);
         sds_pkg::REG_PREV_POSITION: prdata = sds_pkg::DATA_W'(prev_ff);
         default:                    prdata = '0;
      endcase
   end

   // Request intake and clamping.
   assign accept       = req_valid & req_ready;
   assign ins_ok       = accept && (count_ff < CNT_W'(MAX_REQUESTS));
   assign req_clamped  = (req_request_cylinder > last_cyl_ff) ? last_cyl_ff
                                                              : req_request_cylinder;
   assign head_clamped = (head_ff > last_cyl_ff) ? last_cyl_ff : head_ff;

   // Sorted request store.
   sds_chain #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ins       (ins_ok),
      .clr       (emit && leg_final),
      .ins_value (req_clamped),
      .rd_idx    (rd_ptr[IDX_W-1:0]),
      .rd_value  (rd_value)
   );

   // Read pointer: ascending sweeps read at ptr, descending ones at ptr - 1.
   always_comb begin
      case (state_ff)
         sds_pkg::ST_SWEEP1: asc = up_ff;
         sds_pkg::ST_SWEEP2: asc = !up_ff;
         default:            asc = 1'b1;
      endcase
   end

   assign rd_ptr    = asc ? ptr_ff : CNT_W'(ptr_ff - CNT_W'(1));
   assign below     = up_ff ? (rd_value < pos_ff) : (rd_value <= pos_ff);
   assign scan_more = (ptr_ff < count_ff) && below;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done1     = up_ff ? (ptr_ff == count_ff) : (ptr_ff == '0);
   assign leg_dist  = (leg_to >= pos_ff) ? (leg_to - pos_ff) : (pos_ff - leg_to);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sds_pkg::ST_LOAD: begin
            if (accept && req_last_request) state_in = sds_pkg::ST_SCAN;
         end
         sds_pkg::ST_SCAN: begin
            if (!scan_more) state_in = sds_pkg::ST_SWEEP1;
         end
         sds_pkg::ST_SWEEP1: begin
            if (done1) state_in = sds_pkg::ST_END;
         end
         sds_pkg::ST_END: begin
            if (emit) state_in = leg_final ? sds_pkg::ST_LOAD : sds_pkg::ST_SWEEP2;
         end
         sds_pkg::ST_SWEEP2: begin
            if (emit && leg_final) state_in = sds_pkg::ST_LOAD;
         end
         default: state_in = sds_pkg::ST_LOAD;
      endcase
   end

   // State outputs and datapath next values.
   always_comb begin
      req_ready = 1'b0;
      emit      = 1'b0;
      leg_final = 1'b0;
      leg_to    = rd_value;
      ptr_in    = ptr_ff;
      split_in  = split_ff;
      pos_in    = pos_ff;
      up_in     = up_ff;
      unique case (state_ff)
         sds_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (accept && req_last_request) begin
               ptr_in = '0;
               pos_in = head_clamped;
               up_in  = prev_ff < head_clamped;
            end
         end
         sds_pkg::ST_SCAN: begin
            if (scan_more) begin
               ptr_in = CNT_W'(ptr_ff + CNT_W'(1));
            end else begin
               split_in = ptr_ff;
            end
         end
         sds_pkg::ST_SWEEP1: begin
            if (!done1 && out_free) begin
               emit   = 1'b1;
               ptr_in = up_ff ? CNT_W'(ptr_ff + CNT_W'(1)) : CNT_W'(ptr_ff - CNT_W'(1));
            end
         end
         sds_pkg::ST_END: begin
            leg_to    = up_ff ? last_cyl_ff : '0;
            leg_final = up_ff ? (split_ff == '0) : (split_ff == count_ff);
            if (out_free) begin
               emit   = 1'b1;
               ptr_in = split_ff;
            end
         end
         sds_pkg::ST_SWEEP2: begin
            leg_final = up_ff ? (ptr_ff == CNT_W'(1))
                              : (CNT_W'(ptr_ff + CNT_W'(1)) == count_ff);
            if (out_free) begin
               emit   = 1'b1;
               ptr_in = up_ff ? CNT_W'(ptr_ff - CNT_W'(1)) : CNT_W'(ptr_ff + CNT_W'(1));
            end
         end
         default: ;
      endcase
      if (emit) begin
         pos_in = leg_to;
      end
   end

   // Movement total restarts with each schedule.
   always_comb begin
      total_in = total_ff;
      if (accept && req_last_request) begin
         total_in = '0;
      end else if (emit) begin
         total_in = TOT_W'(total_ff + TOT_W'(leg_dist));
      end
   end

   // Request count: grows on stored requests, empties after the final leg.
   always_comb begin
      count_in = count_ff;
      if (emit && leg_final) begin
         count_in = '0;
      end else if (ins_ok) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sds_pkg::ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      split_ff <= split_in;
      pos_ff   <= pos_in;
      up_ff    <= up_in;
      total_ff <= total_in;
      if (emit) begin
         rsp_from_ff  <= pos_ff;
         rsp_to_ff    <= leg_to;
         rsp_dist_ff  <= leg_dist;
         rsp_total_ff <= total_in;
         rsp_last_ff  <= leg_final;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_from_cylinder  = rsp_from_ff;
   assign rsp_to_cylinder    = rsp_to_ff;
   assign rsp_seek_distance  = rsp_dist_ff;
   assign rsp_total_movement = rsp_total_ff;
   assign rsp_last_leg       = rsp_last_ff;

   // The count never passes the row depth.
   `SDS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_REQUESTS))
   // After the final leg the block is back to loading with an empty store.
   `SDS_ASSERT_NEXT(a_final_clears, clock, reset, emit && leg_final,
                    (state_ff == sds_pkg::ST_LOAD) && (count_ff == '0))
   // The return sweep only runs while requests remain on its side.
   `SDS_ASSERT_IMPL(a_sweep2_range, clock, reset, state_ff == sds_pkg::ST_SWEEP2,
                    up_ff ? (ptr_ff != '0) : (ptr_ff < count_ff))

endmodule

// File: rtl/sds_cell.sv
module sds_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ins,
   input  logic                                clr,
   input  logic [sds_pkg::CYL_W-1:0]           ins_value,
   input  sds_pkg::cell_link_type              left,
   output sds_pkg::cell_link_type              link
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [sds_pkg::CYL_W-1:0]   value_ff;
   logic [sds_pkg::CYL_W-1:0]   value_in;
   logic                        le_self;

   // This cell keeps its value when it already sits at or below the new one.
   assign le_self = valid_ff && (value_ff <= ins_value);

   // Insertion: keep, take the new value, or take the left neighbor's value.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (clr) begin
         valid_in = 1'b0;
      end else if (ins) begin
         valid_in = valid_ff | left.valid;
         if (!le_self) begin
            value_in = left.le ? ins_value : left.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.le    = le_self;
   assign link.value = value_ff;

endmodule

// File: rtl/sds_chain.sv
`include "scan_disk_scheduler_macros.svh"

module sds_chain #(
   parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF,
   localparam int IDX_W = $clog2(MAX_REQUESTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ins,
   input  logic                          clr,
   input  logic [sds_pkg::CYL_W-1:0]     ins_value,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [sds_pkg::CYL_W-1:0]     rd_value
);

   localparam int RD_DEPTH = 2 ** IDX_W;

   sds_pkg::cell_link_type        links [MAX_REQUESTS+1];
   logic [sds_pkg::CYL_W-1:0]     rd_tab [RD_DEPTH];

   // The left end of the row always lets the new value in.
   assign links[0] = '{valid: 1'b1, le: 1'b1, value: '0};

   // Row of cells, kept sorted in ascending order from the left.
   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      sds_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins       (ins),
         .clr       (clr),
         .ins_value (ins_value),
         .left      (links[i]),
         .link      (links[i+1])
      );
   end

   // Read port over the cell values; unused codes read zero.
   for (genvar k = 0; k < RD_DEPTH; k++) begin : g_rd
      if (k < MAX_REQUESTS) begin : g_used
         assign rd_tab[k] = links[k+1].value;
      end else begin : g_unused
         assign rd_tab[k] = '0;
      end
   end

   assign rd_value = rd_tab[rd_idx];

   // Occupied cells are contiguous from the left and in ascending order.
   for (genvar i = 2; i <= MAX_REQUESTS; i++) begin : g_chk
      `SDS_ASSERT_IMPL(a_sorted_fill, clock, reset, links[i].valid,
                       links[i-1].valid && (links[i-1].value <= links[i].value))
   end

endmodule

// File: tb/tb.sv
module tb;

   localparam int MAX_REQ         = sds_pkg::MAX_REQUESTS_DEF;
   localparam int CYL_W           = sds_pkg::CYL_W;
   localparam int NCYL_W          = sds_pkg::NCYL_W;
   localparam int TOTAL_W         = sds_pkg::TOTAL_W;
   localparam int ADDR_W          = sds_pkg::ADDR_W;
   localparam int DATA_W          = sds_pkg::DATA_W;
   localparam int TARGET_ITEMS    = 430;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 600000;

   // One seek leg as it leaves the response channel.
   typedef struct packed {
      logic [CYL_W-1:0]   from_cyl;
      logic [CYL_W-1:0]   to_cyl;
      logic [CYL_W-1:0]   distance;
      logic [TOTAL_W-1:0] total;
      logic               last_leg;
   } seek_leg_type;

   // Elevator schedule predictor and the legs it still expects.
   class seek_scoreboard;
      logic [NCYL_W-1:0]  num_cylinders = sds_pkg::NUM_CYL_RESET;
      logic [CYL_W-1:0]   head_position = '0;
      logic [CYL_W-1:0]   previous_position = '0;
      logic [CYL_W-1:0]   request_store[$];
      seek_leg_type       pending_legs[$];
      logic [CYL_W-1:0]   head_now;
      logic [TOTAL_W-1:0] movement;
      int                 errors = 0;

      function void set_register(sds_pkg::reg_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            sds_pkg::REG_NUM_CYLINDERS: num_cylinders = value[NCYL_W-1:0];
            sds_pkg::REG_HEAD_POSITION: head_position = value[CYL_W-1:0];
            sds_pkg::REG_PREV_POSITION: previous_position = value[CYL_W-1:0];
            default: ;
         endcase
      endfunction

      // The cylinder count is held between 2 and 65536.
      function logic [CYL_W-1:0] last_cylinder();
         logic [NCYL_W-1:0] n;
         n = num_cylinders;
         if (n < NCYL_W'(2)) n = NCYL_W'(2);
         if (n > NCYL_W'(65536)) n = NCYL_W'(65536);
         return CYL_W'(n - NCYL_W'(1));
      endfunction

      function void add_leg(logic [CYL_W-1:0] to, logic fin);
         seek_leg_type leg;
         leg.from_cyl = head_now;
         leg.to_cyl   = to;
         leg.distance = (to >= head_now) ? to - head_now : head_now - to;
         movement     = movement + TOTAL_W'(leg.distance);
         leg.total    = movement;
         leg.last_leg = fin;
         pending_legs.push_back(leg);
         head_now = to;
      endfunction

      // Store one request; the last one of a batch produces the whole schedule.
      function void note_request(logic [CYL_W-1:0] cyl, logic last);
         logic [CYL_W-1:0] sorted[MAX_REQ];
         logic [CYL_W-1:0] lastc;
         logic [CYL_W-1:0] item;
         logic [CYL_W-1:0] h;
         int               n;
         int               split;
         int               i;
         int               j;
         lastc = last_cylinder();
         item = (cyl > lastc) ? lastc : cyl;
         if (request_store.size() < MAX_REQ) request_store.push_back(item);
         if (!last) return;

         // Insertion sort of the stored requests.
         n = request_store.size();
         for (i = 0; i < n; i++) begin
            item = request_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > item) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = item;
         end

         h = (head_position > lastc) ? lastc : head_position;
         head_now = h;
         movement = '0;
         if (previous_position < h) begin
            // Upward sweep, the leg to the outer end, then back down.
            split = 0;
            while (split < n && sorted[split] < h) split++;
            for (i = split; i < n; i++) add_leg(sorted[i], 1'b0);
            add_leg(lastc, split == 0);
            for (i = split; i > 0; i--) add_leg(sorted[i-1], i == 1);
         end else begin
            // Downward sweep, the leg to cylinder zero, then back up.
            split = 0;
            while (split < n && sorted[split] <= h) split++;
            for (i = split; i > 0; i--) add_leg(sorted[i-1], 1'b0);
            add_leg('0, split == n);
            for (i = split; i < n; i++) add_leg(sorted[i], i + 1 == n);
         end
         request_store.delete();
      endfunction

      function void check_leg(seek_leg_type got);
         seek_leg_type want;
         if (pending_legs.size() == 0) begin
            $display("%0t: expected no leg, got a leg from %0d to %0d",
                     $time, got.from_cyl, got.to_cyl);
            errors++;
            return;
         end
         want = pending_legs.pop_front();
         if (got.from_cyl !== want.from_cyl) begin
            $display("%0t: from_cylinder expected %0d, got %0d",
                     $time, want.from_cyl, got.from_cyl);
            errors++;
         end
         if (got.to_cyl !== want.to_cyl) begin
            $display("%0t: to_cylinder expected %0d, got %0d", $time, want.to_cyl, got.to_cyl);
            errors++;
         end
         if (got.distance !== want.distance) begin
            $display("%0t: seek_distance expected %0d, got %0d",
                     $time, want.distance, got.distance);
            errors++;
         end
         if (got.total !== want.total) begin
            $display("%0t: total_movement expected %0d, got %0d", $time, want.total, got.total);
            errors++;
         end
         if (got.last_leg !== want.last_leg) begin
            $display("%0t: last_leg expected %0b, got %0b", $time, want.last_leg, got.last_leg);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CYL_W-1:0]    req_request_cylinder = '0;
   logic                req_last_request = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CYL_W-1:0]    rsp_from_cylinder;
   logic [CYL_W-1:0]    rsp_to_cylinder;
   logic [CYL_W-1:0]    rsp_seek_distance;
   logic [TOTAL_W-1:0]  rsp_total_movement;
   logic                rsp_last_leg;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   seek_scoreboard      scoreboard;
   logic [CYL_W-1:0]    batch_q[$];
   int                  items_sent = 0;
   bit                  hold_off_request = 1'b0;
   int                  cycle_count = 0;

   scan_disk_scheduler u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_request_cylinder (req_request_cylinder),
      .req_last_request     (req_last_request),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_from_cylinder    (rsp_from_cylinder),
      .rsp_to_cylinder      (rsp_to_cylinder),
      .rsp_seek_distance    (rsp_seek_distance),
      .rsp_total_movement   (rsp_total_movement),
      .rsp_last_leg         (rsp_last_leg),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Register write followed by a read back. Starts and ends at a falling edge,
   // with the bus left idle at the end so that back-to-back calls do not overlap.
   task automatic apb_write(input sds_pkg::reg_index_type idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] stored;
      stored = (idx == sds_pkg::REG_NUM_CYLINDERS) ? DATA_W'(value[NCYL_W-1:0])
                                                   : DATA_W'(value[CYL_W-1:0]);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      scoreboard.set_register(idx, value);
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored) begin
         $display("%0t: register %s read expected %0d, got %0d",
                  $time, idx.name(), stored, prdata);
         scoreboard.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Let every outstanding leg drain and the block come back to loading.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (scoreboard.pending_legs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [NCYL_W-1:0] ncyl, input logic [CYL_W-1:0] head,
                            input logic [CYL_W-1:0] prev);
      wait_idle();
      apb_write(sds_pkg::REG_NUM_CYLINDERS, DATA_W'(ncyl));
      apb_write(sds_pkg::REG_HEAD_POSITION, DATA_W'(head));
      apb_write(sds_pkg::REG_PREV_POSITION, DATA_W'(prev));
   endtask

   // One request transaction. Starts and ends at a falling edge.
   task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_request_cylinder <= cyl;
      req_last_request     <= last;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_request(cyl, last);
      items_sent++;
      @(negedge clock);
   endtask

   // Send the queued batch; the final entry carries the last mark.
   task automatic send_batch(input bit burst);
      int gap;
      for (int i = 0; i < batch_q.size(); i++) begin
         gap = burst ? 0 : $urandom_range(0, 9);
         send_request(batch_q[i], i == batch_q.size() - 1, gap);
      end
   endtask

   // Random batch with requests spread over the disk, at the head and near it.
   task automatic build_batch(input int size);
      logic [CYL_W-1:0] head;
      logic [CYL_W-1:0] cyl;
      int               span;
      head = scoreboard.head_position;
      span = int'(scoreboard.num_cylinders) + 3;
      if (span > 65535) span = 65535;
      batch_q.delete();
      repeat (size) begin
         case ($urandom_range(0, 4)) inside
            [0:1]: cyl = CYL_W'($urandom_range(0, 65535));
            2: cyl = CYL_W'($urandom_range(0, span));
            3: cyl = head;
            default: cyl = head + CYL_W'($urandom_range(0, 6)) - CYL_W'(3);
         endcase
         batch_q.push_back(cyl);
      end
   endtask

   // Response side: random stalls, bursts of full rate, one long hold-off.
   initial begin : response_side
      int gap;
      int burst_left;
      seek_leg_type got;
      burst_left = 0;
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 30);
            gap = 0;
         end else begin
            gap = $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.from_cyl = rsp_from_cylinder;
         got.to_cyl   = rsp_to_cylinder;
         got.distance = rsp_seek_distance;
         got.total    = rsp_total_movement;
         got.last_leg = rsp_last_leg;
         scoreboard.check_leg(got);
         @(negedge clock);
      end
   end

   // Request side and configuration.
   initial begin : stimulus
      int                phase;
      int                batches;
      int                size;
      int                pick;
      bit                burst;
      logic [NCYL_W-1:0] ncyl;
      logic [CYL_W-1:0]  head;
      logic [CYL_W-1:0]  prev;
      scoreboard = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: head at cylinder zero moving down, one request at the head.
      batch_q = '{16'd0};
      send_batch(1'b0);

      // Count above range, head at the outer end moving up.
      configure(17'h1FFFF, 16'hFFFF, 16'd0);
      batch_q = '{16'hFFFF, 16'd0, 16'd40000};
      send_batch(1'b1);

      // Count below range, head clamped, previous equal to head.
      configure(17'd0, 16'hFFFF, 16'hFFFF);
      batch_q = '{16'hFFFF, 16'd0, 16'd1};
      send_batch(1'b0);

      // Store overflow: the dropped final request still starts the schedule.
      configure(17'd65536, 16'd32768, 16'd32767);
      build_batch(MAX_REQ + 2);
      send_batch(1'b0);

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         case ($urandom_range(0, 4))
            0: begin
               ncyl = NCYL_W'($urandom_range(2, 24));
               head = CYL_W'($urandom_range(0, 30));
            end
            1: begin
               ncyl = NCYL_W'(65536);
               head = CYL_W'($urandom);
            end
            2: begin
               ncyl = NCYL_W'($urandom_range(0, 131071));
               head = CYL_W'($urandom);
            end
            3: begin
               pick = $urandom_range(0, 5);
               case (pick)
                  0: ncyl = NCYL_W'(0);
                  1: ncyl = NCYL_W'(1);
                  2: ncyl = NCYL_W'(2);
                  3: ncyl = NCYL_W'(65535);
                  4: ncyl = NCYL_W'(65536);
                  default: ncyl = NCYL_W'(131071);
               endcase
               head = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            default: begin
               ncyl = NCYL_W'($urandom_range(2, 1000));
               head = CYL_W'($urandom_range(0, 1000));
            end
         endcase
         case ($urandom_range(0, 2))
            0: prev = head;
            1: prev = (head == 0) ? '0 : CYL_W'($urandom_range(0, int'(head) - 1));
            default: prev = CYL_W'($urandom);
         endcase
         configure(ncyl, head, prev);

         if (phase == 2) begin
            // Stall the response side while batches keep arriving back to back.
            hold_off_request = 1'b1;
            repeat (4) begin
               build_batch($urandom_range(6, 12));
               send_batch(1'b1);
            end
         end else begin
            batches = $urandom_range(1, 4);
            repeat (batches) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) size = $urandom_range(1, 6);
               else if (pick < 9) size = $urandom_range(7, MAX_REQ);
               else size = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
               burst = ($urandom_range(0, 3) == 0);
               build_batch(size);
               send_batch(burst);
            end
         end
         phase++;
      end

      wait_idle();
      if (scoreboard.errors == 0 && scoreboard.pending_legs.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
